/* rtl/assert_macros.svh */
// Assertion macros shared by the verification checkers of the 3x3 inverse unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define M3I_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("m3i assertion failed");

// Clocked assertion that is also checked during reset.
`define M3I_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("m3i assertion failed");

`endif

/* rtl/m3i_pkg.sv */
// Shared widths, types and index tables for the 3x3 matrix inverse unit.
// No dependencies.
`default_nettype none
package m3i_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int N_ELEM    = 9;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int ADJ_BITS  = PROD_BITS + 1;
    localparam int HI_BITS   = ADJ_BITS - WORD_BITS;
    localparam int PART_BITS = WORD_BITS + HI_BITS;
    localparam int TERM_BITS = WORD_BITS + ADJ_BITS;
    localparam int DET_BITS  = TERM_BITS + 2;
    localparam int NUM_BITS  = ADJ_BITS + 2 * FRAC_BITS;
    localparam int QB        = WORD_BITS + 1;
    localparam int MAG_BITS  = QB + 1;
    localparam int CMP_BITS  = DET_BITS + QB;

    typedef logic signed [WORD_BITS-1:0] elem_t;
    typedef logic signed [ADJ_BITS-1:0]  adj_t;
    typedef logic signed [DET_BITS-1:0]  det_t;

    typedef struct packed {
        elem_t q;
        logic  clip;
        logic  zero;
    } lane_res_t;

    typedef struct packed {
        elem_t [N_ELEM-1:0] r;
        logic               singular;
        logic               saturated;
    } result_t;

    // adj[k] = a[t0]*a[t1] - a[t2]*a[t3], elements indexed row-major
    localparam logic [3:0] ADJ_TERM [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd6, 4'd2},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    // det = sum over j of a[0][j] * adj[j][0]
    localparam logic [3:0] DET_COL [3] = '{4'd0, 4'd3, 4'd6};

endpackage
`default_nettype wire

/* rtl/matrix3_inverse_unit.sv */
// 3x3 matrix inverse unit: top level.
// Uses m3i_pkg, m3i_front, m3i_lane and m3i_merge.
//
// Takes one signed Q16.16 3x3 matrix per transaction and returns its inverse,
// adj(A)/det(A), each element rounded half away from zero and saturated to 32 bits,
// with a singular flag (all elements zero) and a saturated flag. A new matrix can be
// accepted every cycle while the output skid register is empty. The pipeline has 5
// front stages, WORD_BITS+5 lane stages and one output register. The lanes are nine
// parallel restoring dividers, each resolving one quotient bit per pipeline stage.
// A skid register keeps s_ready registered.
`default_nettype none
module matrix3_inverse_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  m3i_pkg::elem_t          s_a00,
    input  m3i_pkg::elem_t          s_a01,
    input  m3i_pkg::elem_t          s_a02,
    input  m3i_pkg::elem_t          s_a10,
    input  m3i_pkg::elem_t          s_a11,
    input  m3i_pkg::elem_t          s_a12,
    input  m3i_pkg::elem_t          s_a20,
    input  m3i_pkg::elem_t          s_a21,
    input  m3i_pkg::elem_t          s_a22,
    output logic                    m_valid,
    input  logic                    m_ready,
    output m3i_pkg::elem_t          m_r00,
    output m3i_pkg::elem_t          m_r01,
    output m3i_pkg::elem_t          m_r02,
    output m3i_pkg::elem_t          m_r10,
    output m3i_pkg::elem_t          m_r11,
    output m3i_pkg::elem_t          m_r12,
    output m3i_pkg::elem_t          m_r20,
    output m3i_pkg::elem_t          m_r21,
    output m3i_pkg::elem_t          m_r22,
    output logic                    m_singular,
    output logic                    m_saturated
);
    import m3i_pkg::*;

    logic      en;
    elem_t     a_in [N_ELEM];
    logic      front_valid;
    adj_t      adj  [N_ELEM];
    det_t      det;
    logic      lane_valid [N_ELEM];
    lane_res_t lane_res   [N_ELEM];
    result_t   res;

    assign a_in[0] = s_a00;
    assign a_in[1] = s_a01;
    assign a_in[2] = s_a02;
    assign a_in[3] = s_a10;
    assign a_in[4] = s_a11;
    assign a_in[5] = s_a12;
    assign a_in[6] = s_a20;
    assign a_in[7] = s_a21;
    assign a_in[8] = s_a22;

    m3i_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .a_in      (a_in),
        .out_valid (front_valid),
        .adj_out   (adj),
        .det_out   (det)
    );

    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        m3i_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (front_valid),
            .adj_in    (adj[k]),
            .det_in    (det),
            .out_valid (lane_valid[k]),
            .res_out   (lane_res[k])
        );
    end

    m3i_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tail_valid (lane_valid[0]),
        .res_in     (lane_res),
        .en         (en),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (res)
    );

    assign s_ready     = en;
    assign m_r00       = res.r[0];
    assign m_r01       = res.r[1];
    assign m_r02       = res.r[2];
    assign m_r10       = res.r[3];
    assign m_r11       = res.r[4];
    assign m_r12       = res.r[5];
    assign m_r20       = res.r[6];
    assign m_r21       = res.r[7];
    assign m_r22       = res.r[8];
    assign m_singular  = res.singular;
    assign m_saturated = res.saturated;

endmodule
`default_nettype wire

/* rtl/m3i_front.sv */
// Front pipeline: pair products, adjugate and exact determinant (5 stages).
// Depends on m3i_pkg.
`default_nettype none
module m3i_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  m3i_pkg::elem_t  a_in [m3i_pkg::N_ELEM],
    output logic            out_valid,
    output m3i_pkg::adj_t   adj_out [m3i_pkg::N_ELEM],
    output m3i_pkg::det_t   det_out
);
    import m3i_pkg::*;

    logic [4:0]                  vld_reg;
    logic signed [PROD_BITS-1:0] prod_reg [N_ELEM][2];
    elem_t                       arow_reg [2][3];
    adj_t                        adj_reg  [4][N_ELEM];
    logic signed [PART_BITS-1:0] lo_reg   [3];
    logic signed [PART_BITS-1:0] hi_reg   [3];
    logic signed [TERM_BITS-1:0] term_reg [3];
    det_t                        det_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                prod_reg[k][0] <= a_in[ADJ_TERM[k][0]] * a_in[ADJ_TERM[k][1]];
                prod_reg[k][1] <= a_in[ADJ_TERM[k][2]] * a_in[ADJ_TERM[k][3]];
                adj_reg[0][k]  <= ADJ_BITS'(prod_reg[k][0]) - ADJ_BITS'(prod_reg[k][1]);
                adj_reg[1][k]  <= adj_reg[0][k];
                adj_reg[2][k]  <= adj_reg[1][k];
                adj_reg[3][k]  <= adj_reg[2][k];
            end
            for (int j = 0; j < 3; j++) begin
                arow_reg[0][j] <= a_in[j];
                arow_reg[1][j] <= arow_reg[0][j];
                lo_reg[j] <= arow_reg[1][j]
                    * $signed({1'b0, adj_reg[0][DET_COL[j]][WORD_BITS-1:0]});
                hi_reg[j] <= arow_reg[1][j]
                    * $signed(adj_reg[0][DET_COL[j]][ADJ_BITS-1:WORD_BITS]);
                term_reg[j] <= (TERM_BITS'(hi_reg[j]) <<< WORD_BITS)
                    + TERM_BITS'(lo_reg[j]);
            end
            det_reg <= DET_BITS'(term_reg[0]) + DET_BITS'(term_reg[1])
                + DET_BITS'(term_reg[2]);
        end
    end

    assign out_valid = vld_reg[4];
    assign adj_out   = adj_reg[3];
    assign det_out   = det_reg;

endmodule
`default_nettype wire

/* rtl/m3i_lane.sv */
// One inverse lane: signed rounded quotient adj * 2^(2F) / det with saturation,
// built as a pipelined restoring divider, one quotient bit per stage. Depends on m3i_pkg.
`default_nettype none
module m3i_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  m3i_pkg::adj_t       adj_in,
    input  m3i_pkg::det_t       det_in,
    output logic                out_valid,
    output m3i_pkg::lane_res_t  res_out
);
    import m3i_pkg::*;

    typedef struct packed {
        logic [NUM_BITS-1:0] r;
        logic [DET_BITS-1:0] d;
        logic [QB-1:0]       q;
        logic                neg;
        logic                ovf;
        logic                zero;
    } div_t;

    localparam logic [MAG_BITS-1:0] POS_LIM = MAG_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [MAG_BITS-1:0] NEG_LIM = MAG_BITS'(64'd1 << (WORD_BITS - 1));
    localparam elem_t MAX_VAL = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam elem_t MIN_VAL = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic [QB+3:0]              vld_reg;
    logic signed [NUM_BITS-1:0] num;
    logic [NUM_BITS-1:0]        num_mag;
    logic [DET_BITS-1:0]        den_mag;
    div_t                       in_reg;
    div_t                       st_reg [QB+1];
    logic                       rnd;
    logic [MAG_BITS-1:0]        mag_reg;
    logic                       neg_reg;
    logic                       ovf_reg;
    logic                       zero_reg;
    logic [MAG_BITS-1:0]        neg_mag;
    lane_res_t                  res_next;
    lane_res_t                  res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QB+2:0], in_valid};
        end
    end

    assign num     = NUM_BITS'(adj_in) <<< (2 * FRAC_BITS);
    assign num_mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    assign den_mag = det_in[DET_BITS-1] ? DET_BITS'(-det_in) : DET_BITS'(det_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg.r    <= num_mag;
            in_reg.d    <= den_mag;
            in_reg.q    <= '0;
            in_reg.neg  <= num[NUM_BITS-1] ^ det_in[DET_BITS-1];
            in_reg.ovf  <= 1'b0;
            in_reg.zero <= (det_in == '0);
            // quotient would not fit in QB bits
            st_reg[0] <= '{r:    in_reg.r,
                           d:    in_reg.d,
                           q:    in_reg.q,
                           neg:  in_reg.neg,
                           ovf:  CMP_BITS'(in_reg.r) >= (CMP_BITS'(in_reg.d) << QB),
                           zero: in_reg.zero};
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [CMP_BITS-1:0] trial;
        logic [CMP_BITS-1:0] rem;
        div_t                step_next;
        assign trial = CMP_BITS'(st_reg[k].d) << (QB - 1 - k);
        assign rem   = CMP_BITS'(st_reg[k].r);
        always_comb begin
            step_next = st_reg[k];
            if (rem >= trial) begin
                step_next.r         = NUM_BITS'(rem - trial);
                step_next.q[QB-1-k] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= step_next;
            end
        end
    end

    // round half away from zero on the magnitude
    assign rnd = (CMP_BITS'(st_reg[QB].r) << 1) >= CMP_BITS'(st_reg[QB].d);

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= MAG_BITS'(st_reg[QB].q) + MAG_BITS'(rnd);
            neg_reg  <= st_reg[QB].neg;
            ovf_reg  <= st_reg[QB].ovf;
            zero_reg <= st_reg[QB].zero;
        end
    end

    assign neg_mag = MAG_BITS'(0) - mag_reg;

    always_comb begin
        res_next.zero = zero_reg;
        res_next.clip = 1'b0;
        res_next.q    = '0;
        if (!zero_reg) begin
            if (neg_reg) begin
                if (ovf_reg || mag_reg > NEG_LIM) begin
                    res_next.q    = MIN_VAL;
                    res_next.clip = 1'b1;
                end else begin
                    res_next.q = neg_mag[WORD_BITS-1:0];
                end
            end else begin
                if (ovf_reg || mag_reg > POS_LIM) begin
                    res_next.q    = MAX_VAL;
                    res_next.clip = 1'b1;
                end else begin
                    res_next.q = mag_reg[WORD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[QB+3];
    assign res_out   = res_reg;

endmodule
`default_nettype wire

/* rtl/m3i_merge.sv */
// Merge stage: combines the nine lane results and flags, output register plus skid.
// Depends on m3i_pkg.
`default_nettype none
module m3i_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tail_valid,
    input  m3i_pkg::lane_res_t  res_in [m3i_pkg::N_ELEM],
    output logic                en,
    output logic                m_valid,
    input  logic                m_ready,
    output m3i_pkg::result_t    m_res
);
    import m3i_pkg::*;

    result_t merged;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_full_reg;
    logic    take_out;
    logic    any_clip;

    always_comb begin
        any_clip = 1'b0;
        for (int k = 0; k < N_ELEM; k++) begin
            merged.r[k] = res_in[k].q;
            any_clip    = any_clip | res_in[k].clip;
        end
        merged.singular  = res_in[0].zero;
        merged.saturated = any_clip & ~res_in[0].zero;
    end

    assign take_out = ~out_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (take_out) begin
            if (skid_full_reg) begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end else begin
                out_valid_reg <= tail_valid;
            end
        end else if (tail_valid && !skid_full_reg) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_out) begin
            out_reg <= skid_full_reg ? skid_reg : merged;
        end else if (!skid_full_reg) begin
            skid_reg <= merged;
        end
    end

    assign en      = ~skid_full_reg;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule
`default_nettype wire

/* rtl/m3i_checker.sv */
// Port-level checker for matrix3_inverse_unit, bound to the top level.
// Depends on assert_macros.svh and m3i_pkg.
`default_nettype none
`include "assert_macros.svh"
module m3i_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input m3i_pkg::elem_t      m_r00,
    input m3i_pkg::elem_t      m_r01,
    input m3i_pkg::elem_t      m_r02,
    input m3i_pkg::elem_t      m_r10,
    input m3i_pkg::elem_t      m_r11,
    input m3i_pkg::elem_t      m_r12,
    input m3i_pkg::elem_t      m_r20,
    input m3i_pkg::elem_t      m_r21,
    input m3i_pkg::elem_t      m_r22,
    input logic                m_singular,
    input logic                m_saturated
);
    logic all_zero;

    assign all_zero = ((m_r00 | m_r01 | m_r02 | m_r10 | m_r11 | m_r12
                      | m_r20 | m_r21 | m_r22) == '0);

    `M3I_ASSERT(a_sing_no_sat, aclk, aresetn, m_valid && m_singular |-> !m_saturated)
    `M3I_ASSERT(a_sing_zero, aclk, aresetn, m_valid && m_singular |-> all_zero)
    `M3I_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `M3I_ASSERT_NR(a_rst_idle, aclk, !aresetn |=> !m_valid)

endmodule

bind matrix3_inverse_unit m3i_checker u_checker (.*);
`default_nettype wire

/* sim/tb_matrix3_inverse_unit.sv */
// Self-checking testbench for matrix3_inverse_unit: directed and random 3x3 matrices.
// A scoreboard class predicts each inverse with wide exact arithmetic.
// Depends on rtl/m3i_pkg.sv and the matrix3_inverse_unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix3_inverse_unit;
    import m3i_pkg::*;

    typedef logic signed [199:0] wide_t;
    typedef logic [199:0] uwide_t;

    class inverse_scoreboard;
        result_t pending[$];

        function automatic result_t invert(elem_t a[9]);
            wide_t e[9];
            wide_t adj[9];
            wide_t det;
            wide_t n;
            uwide_t num;
            uwide_t den;
            uwide_t uq;
            wide_t q;
            bit neg;
            result_t res;
            res = '0;
            for (int k = 0; k < 9; k++) e[k] = a[k];
            adj[0] = e[4] * e[8] - e[5] * e[7];
            adj[1] = e[2] * e[7] - e[1] * e[8];
            adj[2] = e[1] * e[5] - e[4] * e[2];
            adj[3] = e[6] * e[5] - e[3] * e[8];
            adj[4] = e[0] * e[8] - e[6] * e[2];
            adj[5] = e[3] * e[2] - e[0] * e[5];
            adj[6] = e[3] * e[7] - e[6] * e[4];
            adj[7] = e[6] * e[1] - e[0] * e[7];
            adj[8] = e[0] * e[4] - e[3] * e[1];
            det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
            if (det == 0) begin
                res.singular = 1'b1;
                return res;
            end
            for (int k = 0; k < 9; k++) begin
                n = adj[k] <<< (2 * FRAC_BITS);
                neg = (n < 0) != (det < 0);
                num = (n < 0) ? -n : n;
                den = (det < 0) ? -det : det;
                uq = (2 * num + den) / (2 * den);
                q = neg ? -$signed(uq) : $signed(uq);
                if (q > wide_t'(32'sh7FFFFFFF)) begin
                    res.r[k] = 32'sh7FFFFFFF;
                    res.saturated = 1'b1;
                end else if (q < -wide_t'(64'sh80000000)) begin
                    res.r[k] = 32'sh80000000;
                    res.saturated = 1'b1;
                end else begin
                    res.r[k] = q[31:0];
                end
            end
            return res;
        endfunction

        function void note(elem_t a[9]);
            pending.push_back(invert(a));
        endfunction

        // returns the names of mismatching fields, or unexpected transaction when nothing is pending; empty when good
        function string check(result_t got);
            result_t exp_r;
            string msg;
            msg = "";
            if (pending.size() == 0) return "unexpected transaction";
            exp_r = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.r[k] !== exp_r.r[k])
                    msg = {msg, $sformatf(" r%0d%0d got %h exp %h", k / 3, k % 3,
                                          got.r[k], exp_r.r[k])};
            if (got.singular !== exp_r.singular)
                msg = {msg, $sformatf(" singular got %b", got.singular)};
            if (got.saturated !== exp_r.saturated)
                msg = {msg, $sformatf(" saturated got %b", got.saturated)};
            return msg;
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    elem_t s_a [9] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    elem_t m_r [9];
    logic m_singular;
    logic m_saturated;
    int errors = 0;
    inverse_scoreboard sb = new();

    matrix3_inverse_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a00(s_a[0]), .s_a01(s_a[1]), .s_a02(s_a[2]),
        .s_a10(s_a[3]), .s_a11(s_a[4]), .s_a12(s_a[5]),
        .s_a20(s_a[6]), .s_a21(s_a[7]), .s_a22(s_a[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_r00(m_r[0]), .m_r01(m_r[1]), .m_r02(m_r[2]),
        .m_r10(m_r[3]), .m_r11(m_r[4]), .m_r12(m_r[5]),
        .m_r20(m_r[6]), .m_r21(m_r[7]), .m_r22(m_r[8]),
        .m_singular(m_singular), .m_saturated(m_saturated)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report(string msg);
        errors++;
        $display("ERROR @%0t:%s", $realtime, msg);
    endtask

    task automatic send_matrix(elem_t a[9]);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int k = 0; k < 9; k++) s_a[k] <= a[k];
        do @(posedge aclk); while (!s_ready);
        sb.note(a);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic elem_t rand_elem(int mode);
        case (mode)
            0: return $urandom();
            1: return elem_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
            2: return elem_t'($signed($urandom_range(0, 32'hFF)) - 32'sh7F);
            3: return '0;
            default: return elem_t'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF);
        endcase
    endfunction

    function automatic void diag(ref elem_t a[9], input elem_t d, input elem_t off);
        for (int k = 0; k < 9; k++) a[k] = (k % 4 == 0) ? d : off;
    endfunction

    // result side
    initial begin
        result_t got;
        string msg;
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            for (int k = 0; k < 9; k++) got.r[k] = m_r[k];
            got.singular = m_singular;
            got.saturated = m_saturated;
            msg = sb.check(got);
            if (msg != "") report(msg);
        end
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        elem_t a [9];
        int mode;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        diag(a, 32'sh10000, '0);            send_matrix(a);
        diag(a, '0, '0);                     send_matrix(a);
        diag(a, 32'sh7FFFFFFF, 32'sh7FFFFFFF); send_matrix(a);
        diag(a, 32'sh80000000, 32'sh80000000); send_matrix(a);
        diag(a, 32'sh7FFFFFFF, '0);          send_matrix(a);
        diag(a, 32'sh80000000, '0);          send_matrix(a);
        diag(a, 32'sh80000000, 32'sh7FFFFFFF); send_matrix(a);
        diag(a, 32'sh1, '0);                 send_matrix(a);
        diag(a, -32'sh1, '0);                send_matrix(a);
        diag(a, 32'sh30000, '0);             send_matrix(a);
        diag(a, -32'sh30000, 32'sh10000);    send_matrix(a);
        diag(a, 32'sh20000, 32'sh10000);     send_matrix(a);
        diag(a, 32'sh20000000, '0);          send_matrix(a);
        a = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
              32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000};
        send_matrix(a);
        a = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh0, 32'sh10000,
              32'sh40000, 32'sh50000, 32'sh60000, 32'sh0};
        send_matrix(a);
        a = '{32'sh0, 32'sh10000, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
              32'sh0, 32'sh0, -32'sh10000};
        send_matrix(a);
        a = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh1, -32'sh1, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh80000000, 32'sh1, 32'sh7FFFFFFF};
        send_matrix(a);
        drain();

        for (int i = 0; i < 1830; i++) begin
            mode = $urandom_range(0, 4);
            for (int k = 0; k < 9; k++)
                a[k] = rand_elem(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : mode);
            if ($urandom_range(0, 9) == 0)
                for (int k = 0; k < 3; k++) a[6 + k] = a[3 + k];
            send_matrix(a);
            if (i == 900) drain();
        end
        drain();
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_lane.sv
rtl/m3i_merge.sv
rtl/matrix3_inverse_unit.sv
rtl/m3i_checker.sv
sim/tb_matrix3_inverse_unit.sv
